// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL of the decimal ASCII converter.
// Depends on nothing; files that check their logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// holds at every clock edge outside reset
`define U2DA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("%m: assertion failed");
// condition never true outside reset
`define U2DA_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("%m: forbidden condition seen");
`else
`define U2DA_ASSERT(lbl, clk, rstn, prop)
`define U2DA_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ===== sv/u2da_pkg.sv =====
// Shared constants and types for the unsigned to decimal ASCII converter.
// No dependencies; used by every module of the block.
package u2da_pkg;
	localparam int MAX_DIGITS  = 10;
	localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int IDX_W       = $clog2(MAX_DIGITS);
	localparam int QUEUE_DEPTH = 2;

	// divide by ten: q = (v * RECIP_TEN) >> RECIP_SHIFT, exact for 32-bit v
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic       ST_OK     = 1'b0;
	localparam logic       ST_OVF    = 1'b1;

	typedef logic [3:0] bcd_t;

	// one converted item, digits least significant first
	typedef struct packed {
		logic                  ovf;
		logic [CNT_W-1:0]      ndig;
		bcd_t [MAX_DIGITS-1:0] digits;
	} job_t;
endpackage

// ===== sv/unsigned_to_decimal_ascii_top.sv =====
// Top level of the unsigned 32-bit to decimal ASCII converter.
// Depends on u2da_pkg, u2da_front, u2da_queue and u2da_back.
//
// An item (value, capacity) is taken when start is high and busy is low.
// The front end peels off one decimal digit (1 to 10 in all) per cycle
// with a divide by ten through a reciprocal multiplier, then hands the
// item to a small queue, waiting while it is full; busy stays high until
// the hand-over. The back end then drives one result per cycle with valid high:
// the digits most significant first with status 0 and last on the final
// digit, or one result with digit_char 0, status 1 and last 1 when
// capacity is at most the digit count plus one. Results cannot be held
// off and must be captured in the cycle valid is high. Front and back run
// in parallel, so the sustained rate is set by the digit loop, which is
// longer for values with more digits.
module unsigned_to_decimal_ascii_top import u2da_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic [7:0]  capacity,
	output logic        valid,
	output logic [7:0]  digit_char,
	output logic        status,
	output logic        last
);
	job_t front_job;
	job_t q_job;
	logic job_push;
	logic q_full;
	logic q_empty;
	logic q_pop;

	u2da_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.value    (value),
		.capacity (capacity),
		.job_push (job_push),
		.job      (front_job),
		.q_full   (q_full)
	);

	u2da_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_push),
		.push_job (front_job),
		.full     (q_full),
		.pop      (q_pop),
		.pop_job  (q_job),
		.empty    (q_empty)
	);

	u2da_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_job      (q_job),
		.q_pop      (q_pop),
		.valid      (valid),
		.digit_char (digit_char),
		.status     (status),
		.last       (last)
	);
endmodule

// ===== sv/u2da_front.sv =====
// Front end: accepts an item, peels off decimal digits one per cycle and
// classifies the item against its capacity. Depends on u2da_pkg.
module u2da_front import u2da_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] value,
	input  logic [7:0]  capacity,
	output logic        job_push,
	output job_t        job,
	input  logic        q_full
);
	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CONV = 3'b010,
		F_DONE = 3'b100
	} fstate_t;

	fstate_t               state_q;
	logic [31:0]           val_q;
	logic [7:0]            cap_q;
	logic [CNT_W-1:0]      ndig_q;
	bcd_t [MAX_DIGITS-1:0] dig_q;

	logic [63:0] prod;
	logic [31:0] quo;
	logic [31:0] rem32;
	logic        last_dig;
	logic        accept;

	assign accept   = start && (state_q == F_IDLE);
	assign busy     = (state_q != F_IDLE);
	assign prod     = 64'(val_q) * 64'(RECIP_TEN);
	assign quo      = 32'(prod[63:RECIP_SHIFT]);
	assign rem32    = val_q - ((quo << 3) + (quo << 1));
	assign last_dig = (quo == 32'd0) || (ndig_q == CNT_W'(MAX_DIGITS - 1));

	assign job_push   = (state_q == F_DONE) && !q_full;
	assign job.digits = dig_q;
	assign job.ndig   = ndig_q;
	// too small when digits plus one reach the capacity (zero capacity included)
	assign job.ovf    = (9'(ndig_q) + 9'd1) >= {1'b0, cap_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ndig_q  <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CONV;
						ndig_q  <= '0;
					end
				end
				F_CONV: begin
					ndig_q <= ndig_q + CNT_W'(1);
					if (last_dig) begin
						state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_q <= value;
			cap_q <= capacity;
		end else if (state_q == F_CONV) begin
			val_q                    <= quo;
			dig_q[ndig_q[IDX_W-1:0]] <= rem32[3:0];
		end
	end
endmodule

// ===== sv/u2da_queue.sv =====
// Short queue of classified items between front and back end.
// Depends on u2da_pkg and assert_macros.svh.
`include "assert_macros.svh"
module u2da_queue import u2da_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output job_t pop_job,
	output logic empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`U2DA_NEVER(a_no_push_full, clk, arst_n, push && full)
	`U2DA_NEVER(a_no_pop_empty, clk, arst_n, pop && empty)
	`U2DA_ASSERT(a_cnt_grows, clk, arst_n, (push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
endmodule

// ===== sv/u2da_back.sv =====
// Back end: takes classified items from the queue and emits one result per
// cycle, most significant digit first. Depends on u2da_pkg.
module u2da_back import u2da_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  job_t       q_job,
	output logic       q_pop,
	output logic       valid,
	output logic [7:0] digit_char,
	output logic       status,
	output logic       last
);
	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_EMIT = 2'b10
	} bstate_t;

	bstate_t          state_q;
	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic             emit;
	logic             final_res;

	assign emit      = (state_q == B_EMIT);
	assign final_res = job_q.ovf || (idx_q == '0);
	// next item is taken in the same cycle as the previous item's final result
	assign q_pop     = !q_empty && (!emit || final_res);

	assign valid      = emit;
	assign status     = job_q.ovf ? ST_OVF : ST_OK;
	assign last       = final_res;
	assign digit_char = job_q.ovf ? CHAR_NUL : CHAR_ZERO + 8'(job_q.digits[idx_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						state_q <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (final_res && !q_pop) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			idx_q <= IDX_W'(q_job.ndig - CNT_W'(1));
		end else if (emit) begin
			idx_q <= idx_q - IDX_W'(1);
		end
	end
endmodule
